### hdl/gcc_pkg.sv
// ----------------------------------------------------------------------------
// gcc_pkg
// Types and constants shared by the grapheme cluster classifier modules.
// ----------------------------------------------------------------------------
package gcc_pkg;

  localparam int CP_W    = 21;
  localparam int CW_W    = 2;
  localparam int CELLS_W = 4;
  localparam int CLASS_W = 5;
  localparam int FLAGS_W = 9;
  localparam int TOTAL_W = 8;

  localparam int QUEUE_DEPTH = 2;

  localparam logic [CP_W-1:0] CP_ZWJ      = 21'h0200D;
  localparam logic [CP_W-1:0] CP_KEYCAP   = 21'h020E3;
  localparam logic [CP_W-1:0] CP_TEXTVS   = 21'h0FE0E;
  localparam logic [CP_W-1:0] CP_EMOJIVS  = 21'h0FE0F;
  localparam logic [CP_W-1:0] CP_HEART    = 21'h02764;
  localparam logic [CP_W-1:0] CP_RI_LO    = 21'h1F1E6;
  localparam logic [CP_W-1:0] CP_RI_HI    = 21'h1F1FF;
  localparam logic [CP_W-1:0] CP_TAG_LO   = 21'hE0020;
  localparam logic [CP_W-1:0] CP_TAG_HI   = 21'hE007F;
  localparam logic [CP_W-1:0] CP_MOD_LO   = 21'h1F3FB;
  localparam logic [CP_W-1:0] CP_MOD_HI   = 21'h1F3FF;
  localparam logic [CP_W-1:0] CP_EMO_LO   = 21'h1F000;
  localparam logic [CP_W-1:0] CP_EMO_HI   = 21'h1FAFF;
  localparam logic [CP_W-1:0] CP_SYM_LO   = 21'h02600;
  localparam logic [CP_W-1:0] CP_SYM_HI   = 21'h027BF;
  localparam logic [CP_W-1:0] CP_PUA_LO   = 21'h0E000;
  localparam logic [CP_W-1:0] CP_PUA_HI   = 21'h0F8FF;
  localparam logic [CP_W-1:0] CP_PUA15_LO = 21'h0F0000;
  localparam logic [CP_W-1:0] CP_PUA15_HI = 21'h0FFFFD;
  localparam logic [CP_W-1:0] CP_PUA16_LO = 21'h100000;
  localparam logic [CP_W-1:0] CP_PUA16_HI = 21'h10FFFD;
  localparam logic [CP_W-1:0] CP_DIGIT_LO = 21'h00030;
  localparam logic [CP_W-1:0] CP_DIGIT_HI = 21'h00039;
  localparam logic [CP_W-1:0] CP_HASH     = 21'h00023;
  localparam logic [CP_W-1:0] CP_STAR     = 21'h0002A;
  localparam logic [CP_W-1:0] CP_ASCII_LIM = 21'h00080;

  localparam int FL_ALLREG  = 0;
  localparam int FL_ZWJ     = 1;
  localparam int FL_KEYCAP  = 2;
  localparam int FL_TEXTVS  = 3;
  localparam int FL_EMOJIVS = 4;
  localparam int FL_MOD     = 5;
  localparam int FL_HEART   = 6;
  localparam int FL_TAG     = 7;
  localparam int FL_TRUNC   = 8;

  localparam logic [FLAGS_W-1:0] FLAGS_RESET = 9'h001;

  typedef enum logic [CLASS_W-1:0] {
    CLS_UNKNOWN   = 5'd0,
    CLS_KEYCAP    = 5'd1,
    CLS_FLAG      = 5'd2,
    CLS_REGIONAL  = 5'd3,
    CLS_TAGFLAG   = 5'd4,
    CLS_HEARTZWJ  = 5'd5,
    CLS_FAMILYZWJ = 5'd6,
    CLS_SHORTZWJ  = 5'd7,
    CLS_MODIFIER  = 5'd8,
    CLS_EMOJIVS   = 5'd9,
    CLS_TEXTVS    = 5'd10,
    CLS_STACK     = 5'd11,
    CLS_COMBINING = 5'd12,
    CLS_EMOJI     = 5'd13,
    CLS_WIDE      = 5'd14,
    CLS_PRIVATE   = 5'd15,
    CLS_ASCII     = 5'd16,
    CLS_AMBIGUOUS = 5'd17
  } term_class_e;

  // decoded codepoint as it travels from front to back
  typedef struct packed {
    logic [CP_W-1:0]    cp;
    logic [CELLS_W-1:0] cells;
    logic               last;
    logic               spacing;
    logic               regional;
    logic               zwj;
    logic               keycap;
    logic               textvs;
    logic               emojivs;
    logic               modifier;
    logic               heart;
    logic               tag;
    logic               keybase;
    logic               emojiish;
    logic               priv;
    logic               ascii;
  } token_t;

  typedef struct packed {
    logic [CLASS_W-1:0] term_class;
    logic [FLAGS_W-1:0] fact_flags;
    logic [TOTAL_W-1:0] cp_total;
    logic [TOTAL_W-1:0] spacing_total;
    logic [TOTAL_W-1:0] regional_total;
    logic [TOTAL_W-1:0] joiner_total;
    logic [CP_W-1:0]    first_cp;
    logic [CP_W-1:0]    keycap_digit;
    logic [CELLS_W-1:0] display_width;
  } result_t;

endpackage

### hdl/gcc_if.sv
// ----------------------------------------------------------------------------
// gcc_if
// Valid/ready channels for codepoints in and cluster results out.
// ----------------------------------------------------------------------------
interface gcc_in_if;
  logic                          valid;
  logic                          ready;
  logic [gcc_pkg::CP_W-1:0]      codepoint;
  logic [gcc_pkg::CW_W-1:0]      cp_cell_width;
  logic [gcc_pkg::CELLS_W-1:0]   cluster_cells;
  logic                          last;

  modport source (output valid, codepoint, cp_cell_width, cluster_cells, last,
                  input ready);
  modport sink (input valid, codepoint, cp_cell_width, cluster_cells, last,
                output ready);
endinterface

interface gcc_out_if;
  logic                          valid;
  logic                          ready;
  logic [gcc_pkg::CLASS_W-1:0]   term_class;
  logic [gcc_pkg::FLAGS_W-1:0]   fact_flags;
  logic [gcc_pkg::TOTAL_W-1:0]   cp_total;
  logic [gcc_pkg::TOTAL_W-1:0]   spacing_total;
  logic [gcc_pkg::TOTAL_W-1:0]   regional_total;
  logic [gcc_pkg::TOTAL_W-1:0]   joiner_total;
  logic [gcc_pkg::CP_W-1:0]      first_cp;
  logic [gcc_pkg::CP_W-1:0]      keycap_digit;
  logic [gcc_pkg::CELLS_W-1:0]   display_width;

  modport source (output valid, term_class, fact_flags, cp_total, spacing_total,
                  regional_total, joiner_total, first_cp, keycap_digit,
                  display_width, input ready);
  modport sink (input valid, term_class, fact_flags, cp_total, spacing_total,
                regional_total, joiner_total, first_cp, keycap_digit,
                display_width, output ready);
endinterface

### hdl/gcc_front.sv
// ----------------------------------------------------------------------------
// gcc_front
// Takes codepoints in and decodes each one into a token of range hits.
// ----------------------------------------------------------------------------
module gcc_front (
  input  logic [gcc_pkg::CP_W-1:0]    codepoint_i,
  input  logic [gcc_pkg::CW_W-1:0]    cp_cell_width_i,
  input  logic [gcc_pkg::CELLS_W-1:0] cluster_cells_i,
  input  logic                        last_i,
  output gcc_pkg::token_t             tok_o
);
  import gcc_pkg::*;

  function automatic logic in_range(logic [CP_W-1:0] c, logic [CP_W-1:0] lo,
                                    logic [CP_W-1:0] hi);
    return (c >= lo) && (c <= hi);
  endfunction

  always_comb begin
    tok_o.cp       = codepoint_i;
    tok_o.cells    = cluster_cells_i;
    tok_o.last     = last_i;
    tok_o.spacing  = (cp_cell_width_i != '0);
    tok_o.regional = in_range(codepoint_i, CP_RI_LO, CP_RI_HI);
    tok_o.zwj      = (codepoint_i == CP_ZWJ);
    tok_o.keycap   = (codepoint_i == CP_KEYCAP);
    tok_o.textvs   = (codepoint_i == CP_TEXTVS);
    tok_o.emojivs  = (codepoint_i == CP_EMOJIVS);
    tok_o.modifier = in_range(codepoint_i, CP_MOD_LO, CP_MOD_HI);
    tok_o.heart    = (codepoint_i == CP_HEART);
    tok_o.tag      = in_range(codepoint_i, CP_TAG_LO, CP_TAG_HI);
    tok_o.keybase  = in_range(codepoint_i, CP_DIGIT_LO, CP_DIGIT_HI)
                     || (codepoint_i == CP_HASH) || (codepoint_i == CP_STAR);
    tok_o.emojiish = in_range(codepoint_i, CP_EMO_LO, CP_EMO_HI)
                     || in_range(codepoint_i, CP_SYM_LO, CP_SYM_HI);
    tok_o.priv     = in_range(codepoint_i, CP_PUA_LO, CP_PUA_HI)
                     || in_range(codepoint_i, CP_PUA15_LO, CP_PUA15_HI)
                     || in_range(codepoint_i, CP_PUA16_LO, CP_PUA16_HI);
    tok_o.ascii    = (codepoint_i < CP_ASCII_LIM);
  end

endmodule

### hdl/gcc_queue.sv
// ----------------------------------------------------------------------------
// gcc_queue
// Short token queue between the decode front and the accumulating back.
// ----------------------------------------------------------------------------
module gcc_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_valid_i,
  output logic            push_ready_o,
  input  gcc_pkg::token_t push_tok_i,
  output logic            pop_valid_o,
  input  logic            pop_ready_i,
  output gcc_pkg::token_t pop_tok_o
);
  import gcc_pkg::*;

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  token_t             mem_q [QUEUE_DEPTH];
  logic [PTR_W-1:0]   wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0]   rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0]   count_q, count_d;
  logic               push, pop;

  function automatic logic [PTR_W-1:0] ptr_inc(logic [PTR_W-1:0] p);
    return (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + PTR_W'(1);
  endfunction

  assign push_ready_o = (count_q != CNT_W'(QUEUE_DEPTH));
  assign pop_valid_o  = (count_q != '0);
  assign pop_tok_o    = mem_q[rd_ptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  always_comb begin
    wr_ptr_d = push ? ptr_inc(wr_ptr_q) : wr_ptr_q;
    rd_ptr_d = pop ? ptr_inc(rd_ptr_q) : rd_ptr_q;
    count_d  = count_q;
    if (push && !pop) begin
      count_d = count_q + CNT_W'(1);
    end else if (pop && !push) begin
      count_d = count_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_tok_i;
    end
  end

endmodule

### hdl/gcc_back.sv
// ----------------------------------------------------------------------------
// gcc_back
// Accumulates cluster facts from tokens and registers one result per cluster.
// ----------------------------------------------------------------------------
module gcc_back #(
  parameter int MAX_STORED = 16,
  parameter int COUNT_BITS = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             tok_valid_i,
  output logic             tok_ready_o,
  input  gcc_pkg::token_t  tok_i,
  output logic             res_valid_o,
  input  logic             res_ready_i,
  output gcc_pkg::result_t res_o
);
  import gcc_pkg::*;

  localparam int CMP_W = (COUNT_BITS > TOTAL_W) ? COUNT_BITS : TOTAL_W;

  logic [COUNT_BITS-1:0] cnt_cp_q, cnt_cp_d;
  logic [COUNT_BITS-1:0] cnt_sp_q, cnt_sp_d;
  logic [COUNT_BITS-1:0] cnt_ri_q, cnt_ri_d;
  logic [COUNT_BITS-1:0] cnt_zwj_q, cnt_zwj_d;
  logic [FLAGS_W-1:0]    flags_q, flags_d;
  logic [CP_W-1:0]       first_q, first_d;
  logic                  first_emo_q, first_emo_d;
  logic                  first_priv_q, first_priv_d;
  logic                  first_ascii_q, first_ascii_d;
  logic [CP_W-1:0]       keycap_q, keycap_d;
  logic                  res_valid_q, res_valid_d;
  result_t               res_q, res_d;
  term_class_e           cls;
  logic                  pop, start;

  function automatic logic [COUNT_BITS-1:0] sat_inc(logic [COUNT_BITS-1:0] v);
    return (v == '1) ? v : v + COUNT_BITS'(1);
  endfunction

  function automatic logic [TOTAL_W-1:0] sat_out(logic [COUNT_BITS-1:0] v);
    return (CMP_W'(v) > CMP_W'(255)) ? '1 : TOTAL_W'(v);
  endfunction

  assign tok_ready_o = !tok_i.last || !res_valid_q || res_ready_i;
  assign pop         = tok_valid_i && tok_ready_o;
  assign start       = (cnt_cp_q == '0);

  // state update for this token
  always_comb begin
    cnt_cp_d  = sat_inc(cnt_cp_q);
    cnt_sp_d  = tok_i.spacing ? sat_inc(cnt_sp_q) : cnt_sp_q;
    cnt_ri_d  = tok_i.regional ? sat_inc(cnt_ri_q) : cnt_ri_q;
    cnt_zwj_d = tok_i.zwj ? sat_inc(cnt_zwj_q) : cnt_zwj_q;

    flags_d = flags_q;
    if (CMP_W'(cnt_cp_q) >= CMP_W'(MAX_STORED)) begin
      flags_d[FL_TRUNC] = 1'b1;
    end
    if (!tok_i.regional) begin
      flags_d[FL_ALLREG] = 1'b0;
    end
    if (tok_i.zwj) begin
      flags_d[FL_ZWJ] = 1'b1;
    end
    if (tok_i.keycap) begin
      flags_d[FL_KEYCAP] = 1'b1;
    end
    if (tok_i.textvs) begin
      flags_d[FL_TEXTVS] = 1'b1;
    end
    if (tok_i.emojivs) begin
      flags_d[FL_EMOJIVS] = 1'b1;
    end
    if (tok_i.modifier) begin
      flags_d[FL_MOD] = 1'b1;
    end
    if (tok_i.heart) begin
      flags_d[FL_HEART] = 1'b1;
    end
    if (tok_i.tag) begin
      flags_d[FL_TAG] = 1'b1;
    end

    first_d       = start ? tok_i.cp : first_q;
    first_emo_d   = start ? tok_i.emojiish : first_emo_q;
    first_priv_d  = start ? tok_i.priv : first_priv_q;
    first_ascii_d = start ? tok_i.ascii : first_ascii_q;
    keycap_d      = ((keycap_q == '0) && tok_i.keybase) ? tok_i.cp : keycap_q;
  end

  // terminal class from the updated facts
  always_comb begin
    if (cnt_cp_d == '0) begin
      cls = CLS_UNKNOWN;
    end else if (flags_d[FL_KEYCAP]) begin
      cls = CLS_KEYCAP;
    end else if (flags_d[FL_ALLREG] && (cnt_ri_d == COUNT_BITS'(2))) begin
      cls = CLS_FLAG;
    end else if (flags_d[FL_ALLREG] && (cnt_ri_d == COUNT_BITS'(1))) begin
      cls = CLS_REGIONAL;
    end else if (flags_d[FL_TAG]) begin
      cls = CLS_TAGFLAG;
    end else if (cnt_zwj_d != '0) begin
      if (flags_d[FL_HEART]) begin
        cls = CLS_HEARTZWJ;
      end else if ((cnt_zwj_d >= COUNT_BITS'(2)) || (cnt_sp_d >= COUNT_BITS'(3))) begin
        cls = CLS_FAMILYZWJ;
      end else begin
        cls = CLS_SHORTZWJ;
      end
    end else if (flags_d[FL_MOD]) begin
      cls = CLS_MODIFIER;
    end else if (flags_d[FL_EMOJIVS]) begin
      cls = CLS_EMOJIVS;
    end else if (flags_d[FL_TEXTVS]) begin
      cls = CLS_TEXTVS;
    end else if (cnt_cp_d > COUNT_BITS'(1)) begin
      if (tok_i.cells <= CELLS_W'(1)) begin
        cls = (cnt_cp_d > COUNT_BITS'(2)) ? CLS_STACK : CLS_COMBINING;
      end else begin
        cls = first_emo_d ? CLS_EMOJI : CLS_WIDE;
      end
    end else if (first_priv_d) begin
      cls = CLS_PRIVATE;
    end else if (tok_i.cells >= CELLS_W'(2)) begin
      cls = first_emo_d ? CLS_EMOJI : CLS_WIDE;
    end else if (first_ascii_d) begin
      cls = CLS_ASCII;
    end else if (tok_i.cells == '0) begin
      cls = CLS_COMBINING;
    end else begin
      cls = CLS_AMBIGUOUS;
    end
  end

  always_comb begin
    res_d.term_class     = cls;
    res_d.fact_flags     = flags_d;
    res_d.cp_total       = sat_out(cnt_cp_d);
    res_d.spacing_total  = sat_out(cnt_sp_d);
    res_d.regional_total = sat_out(cnt_ri_d);
    res_d.joiner_total   = sat_out(cnt_zwj_d);
    res_d.first_cp       = first_d;
    res_d.keycap_digit   = keycap_d;
    res_d.display_width  = (tok_i.cells == '0) ? CELLS_W'(1) : tok_i.cells;

    res_valid_d = res_valid_q;
    if (pop && tok_i.last) begin
      res_valid_d = 1'b1;
    end else if (res_ready_i) begin
      res_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_cp_q      <= '0;
      cnt_sp_q      <= '0;
      cnt_ri_q      <= '0;
      cnt_zwj_q     <= '0;
      flags_q       <= FLAGS_RESET;
      first_q       <= '0;
      first_emo_q   <= 1'b0;
      first_priv_q  <= 1'b0;
      first_ascii_q <= 1'b0;
      keycap_q      <= '0;
      res_valid_q   <= 1'b0;
    end else begin
      res_valid_q <= res_valid_d;
      if (pop) begin
        if (tok_i.last) begin
          cnt_cp_q      <= '0;
          cnt_sp_q      <= '0;
          cnt_ri_q      <= '0;
          cnt_zwj_q     <= '0;
          flags_q       <= FLAGS_RESET;
          first_q       <= '0;
          first_emo_q   <= 1'b0;
          first_priv_q  <= 1'b0;
          first_ascii_q <= 1'b0;
          keycap_q      <= '0;
        end else begin
          cnt_cp_q      <= cnt_cp_d;
          cnt_sp_q      <= cnt_sp_d;
          cnt_ri_q      <= cnt_ri_d;
          cnt_zwj_q     <= cnt_zwj_d;
          flags_q       <= flags_d;
          first_q       <= first_d;
          first_emo_q   <= first_emo_d;
          first_priv_q  <= first_priv_d;
          first_ascii_q <= first_ascii_d;
          keycap_q      <= keycap_d;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop && tok_i.last) begin
      res_q <= res_d;
    end
  end

  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

endmodule

### hdl/grapheme_cluster_classifier.sv
// ----------------------------------------------------------------------------
// grapheme_cluster_classifier
// Gathers facts over the codepoints of a grapheme cluster and classifies it.
// ----------------------------------------------------------------------------
// One codepoint is taken per clock cycle while the queue has room. Each is
// decoded into range hits by the front, passes a two-entry queue and is
// folded into the cluster counters and flags by the back; the codepoint
// marked last loads the result register, valid in the cycle after the back
// takes it. The queue and the result register let intake go on while a
// result waits, and only a last codepoint meeting a still-full result register stalls the back.
module grapheme_cluster_classifier #(
  parameter int MAX_STORED = 16,
  parameter int COUNT_BITS = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  gcc_in_if.sink      in_i,
  gcc_out_if.source   out_o
);
  import gcc_pkg::*;

  token_t  front_tok;
  token_t  back_tok;
  logic    back_valid;
  logic    back_ready;
  logic    res_valid;
  result_t res;

  gcc_front u_front (
    .codepoint_i     (in_i.codepoint),
    .cp_cell_width_i (in_i.cp_cell_width),
    .cluster_cells_i (in_i.cluster_cells),
    .last_i          (in_i.last),
    .tok_o           (front_tok)
  );

  gcc_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (in_i.valid),
    .push_ready_o (in_i.ready),
    .push_tok_i   (front_tok),
    .pop_valid_o  (back_valid),
    .pop_ready_i  (back_ready),
    .pop_tok_o    (back_tok)
  );

  gcc_back #(
    .MAX_STORED (MAX_STORED),
    .COUNT_BITS (COUNT_BITS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .tok_valid_i (back_valid),
    .tok_ready_o (back_ready),
    .tok_i       (back_tok),
    .res_valid_o (res_valid),
    .res_ready_i (out_o.ready),
    .res_o       (res)
  );

  assign out_o.valid          = res_valid;
  assign out_o.term_class     = res.term_class;
  assign out_o.fact_flags     = res.fact_flags;
  assign out_o.cp_total       = res.cp_total;
  assign out_o.spacing_total  = res.spacing_total;
  assign out_o.regional_total = res.regional_total;
  assign out_o.joiner_total   = res.joiner_total;
  assign out_o.first_cp       = res.first_cp;
  assign out_o.keycap_digit   = res.keycap_digit;
  assign out_o.display_width  = res.display_width;

endmodule

### hdl/gcc_checker.sv
// ----------------------------------------------------------------------------
// gcc_checker
// Port-level checks on the result channel of the classifier.
// ----------------------------------------------------------------------------
module gcc_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          valid_i,
  input logic                          ready_i,
  input logic [gcc_pkg::CLASS_W-1:0]   term_class_i,
  input logic [gcc_pkg::FLAGS_W-1:0]   fact_flags_i,
  input logic [gcc_pkg::TOTAL_W-1:0]   cp_total_i,
  input logic [gcc_pkg::TOTAL_W-1:0]   spacing_total_i,
  input logic [gcc_pkg::TOTAL_W-1:0]   regional_total_i,
  input logic [gcc_pkg::TOTAL_W-1:0]   joiner_total_i,
  input logic [gcc_pkg::CELLS_W-1:0]   display_width_i
);
  import gcc_pkg::*;

  // stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_i && !ready_i |=> valid_i && $stable(term_class_i)
      && $stable(fact_flags_i) && $stable(cp_total_i))
    else $error("result changed while stalled");

  // every cluster has at least one codepoint and a class
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_i |-> (cp_total_i != '0) && (term_class_i != CLS_UNKNOWN)
      && (display_width_i != '0))
    else $error("empty cluster result");

  // sub-counts never exceed the codepoint count
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_i |-> (spacing_total_i <= cp_total_i) && (regional_total_i <= cp_total_i)
      && (joiner_total_i <= cp_total_i))
    else $error("sub-count above codepoint count");

  // class agrees with the flags that select it
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_i && (term_class_i == CLS_KEYCAP) |-> fact_flags_i[FL_KEYCAP])
    else $error("keycap class without keycap flag");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_i && (term_class_i == CLS_FLAG) |->
      fact_flags_i[FL_ALLREG] && (regional_total_i == TOTAL_W'(2)))
    else $error("flag class without two regional indicators");

endmodule

bind grapheme_cluster_classifier gcc_checker u_gcc_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .valid_i          (out_o.valid),
  .ready_i          (out_o.ready),
  .term_class_i     (out_o.term_class),
  .fact_flags_i     (out_o.fact_flags),
  .cp_total_i       (out_o.cp_total),
  .spacing_total_i  (out_o.spacing_total),
  .regional_total_i (out_o.regional_total),
  .joiner_total_i   (out_o.joiner_total),
  .display_width_i  (out_o.display_width)
);

### test/gcc_cluster_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// gcc_cluster_checker
// Watches both channels of the grapheme cluster classifier. Each codepoint
// transfer is folded into a private copy of the cluster state, and the
// codepoint marked last queues the predicted cluster result. Every result
// transfer is compared field by field with the oldest queued prediction.
// ----------------------------------------------------------------------------
module gcc_cluster_checker #(
  parameter int MAX_STORED   = 16,
  parameter int REPORT_LIMIT = 20
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  gcc_in_if           cp_i,
  gcc_out_if          res_i,
  output int          fail_count_o,
  output int          pending_o,
  output int          results_o,
  output logic [17:0] class_mask_o
);
  import gcc_pkg::*;

  logic [TOTAL_W-1:0] cp_cnt, spc_cnt, ri_cnt, zwj_cnt;
  logic [FLAGS_W-1:0] flags;
  logic [CP_W-1:0]    first_cp, keycap_cp;

  result_t            cluster_results_q [$];
  result_t            want;
  int                 fail_cnt;
  int                 results_seen;
  int                 pending_cnt;
  logic [17:0]        class_seen;

  assign fail_count_o = fail_cnt;
  assign pending_o    = pending_cnt;
  assign results_o    = results_seen;
  assign class_mask_o = class_seen;

  function automatic logic [TOTAL_W-1:0] sat_inc(input logic [TOTAL_W-1:0] v);
    return (v == '1) ? v : v + TOTAL_W'(1);
  endfunction

  function automatic logic cp_between(input logic [CP_W-1:0] c, input logic [CP_W-1:0] lo,
                                      input logic [CP_W-1:0] hi);
    return (c >= lo) && (c <= hi);
  endfunction

  function automatic logic is_emoji(input logic [CP_W-1:0] c);
    return cp_between(c, CP_EMO_LO, CP_EMO_HI) || cp_between(c, CP_SYM_LO, CP_SYM_HI);
  endfunction

  function automatic term_class_e classify_cluster(input logic [CELLS_W-1:0] cells);
    if (cp_cnt == 0) return CLS_UNKNOWN;
    if (flags[FL_KEYCAP]) return CLS_KEYCAP;
    if (flags[FL_ALLREG] && ri_cnt == 2) return CLS_FLAG;
    if (flags[FL_ALLREG] && ri_cnt == 1) return CLS_REGIONAL;
    if (flags[FL_TAG]) return CLS_TAGFLAG;
    if (zwj_cnt != 0) begin
      if (flags[FL_HEART]) return CLS_HEARTZWJ;
      if (zwj_cnt >= 2 || spc_cnt >= 3) return CLS_FAMILYZWJ;
      return CLS_SHORTZWJ;
    end
    if (flags[FL_MOD]) return CLS_MODIFIER;
    if (flags[FL_EMOJIVS]) return CLS_EMOJIVS;
    if (flags[FL_TEXTVS]) return CLS_TEXTVS;
    if (cp_cnt > 1) begin
      if (cells <= 1) return (cp_cnt > 2) ? CLS_STACK : CLS_COMBINING;
      return is_emoji(first_cp) ? CLS_EMOJI : CLS_WIDE;
    end
    if (cp_between(first_cp, CP_PUA_LO, CP_PUA_HI) ||
        cp_between(first_cp, CP_PUA15_LO, CP_PUA15_HI) ||
        cp_between(first_cp, CP_PUA16_LO, CP_PUA16_HI)) return CLS_PRIVATE;
    if (cells >= 2) return is_emoji(first_cp) ? CLS_EMOJI : CLS_WIDE;
    if (first_cp < CP_ASCII_LIM) return CLS_ASCII;
    if (cells == 0) return CLS_COMBINING;
    return CLS_AMBIGUOUS;
  endfunction

  task automatic clear_cluster();
    cp_cnt    = '0;
    spc_cnt   = '0;
    ri_cnt    = '0;
    zwj_cnt   = '0;
    flags     = FLAGS_RESET;
    first_cp  = '0;
    keycap_cp = '0;
  endtask

  task automatic fold_codepoint(input logic [CP_W-1:0] cp, input logic [CW_W-1:0] cw,
                                input logic [CELLS_W-1:0] cells, input logic last);
    result_t res;
    if (cp_cnt == 0) first_cp = cp;
    if (cp_cnt >= MAX_STORED) flags[FL_TRUNC] = 1'b1;
    cp_cnt = sat_inc(cp_cnt);
    if (cw != 0) spc_cnt = sat_inc(spc_cnt);
    if (cp_between(cp, CP_RI_LO, CP_RI_HI)) ri_cnt = sat_inc(ri_cnt);
    else flags[FL_ALLREG] = 1'b0;

    if (cp == CP_ZWJ) begin
      zwj_cnt = sat_inc(zwj_cnt);
      flags[FL_ZWJ] = 1'b1;
    end else if (cp == CP_KEYCAP) begin
      flags[FL_KEYCAP] = 1'b1;
    end else if (cp == CP_TEXTVS) begin
      flags[FL_TEXTVS] = 1'b1;
    end else if (cp == CP_EMOJIVS) begin
      flags[FL_EMOJIVS] = 1'b1;
    end else if (cp_between(cp, CP_MOD_LO, CP_MOD_HI)) begin
      flags[FL_MOD] = 1'b1;
    end else if (cp == CP_HEART) begin
      flags[FL_HEART] = 1'b1;
    end else if (cp_between(cp, CP_TAG_LO, CP_TAG_HI)) begin
      flags[FL_TAG] = 1'b1;
    end

    if (keycap_cp == 0 &&
        (cp_between(cp, CP_DIGIT_LO, CP_DIGIT_HI) || cp == CP_HASH || cp == CP_STAR))
      keycap_cp = cp;

    if (last) begin
      res.term_class     = classify_cluster(cells);
      res.fact_flags     = flags;
      res.cp_total       = cp_cnt;
      res.spacing_total  = spc_cnt;
      res.regional_total = ri_cnt;
      res.joiner_total   = zwj_cnt;
      res.first_cp       = first_cp;
      res.keycap_digit   = keycap_cp;
      res.display_width  = (cells != 0) ? cells : CELLS_W'(1);
      cluster_results_q.push_back(res);
      clear_cluster();
    end
  endtask

  task automatic report_mismatch(input string msg);
    fail_cnt++;
    if (fail_cnt <= REPORT_LIMIT) $display("mismatch: %s", msg);
  endtask

  task automatic check_field(input string name, input logic [31:0] got,
                             input logic [31:0] exp_val);
    if (got !== exp_val)
      report_mismatch($sformatf("result %0d %s is 0x%0h, predicted 0x%0h",
                                results_seen, name, got, exp_val));
  endtask

  initial begin
    fail_cnt     = 0;
    results_seen = 0;
    pending_cnt  = 0;
    class_seen   = '0;
    clear_cluster();
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clear_cluster();
      cluster_results_q.delete();
      pending_cnt = 0;
    end else begin
      if (cp_i.valid && cp_i.ready)
        fold_codepoint(cp_i.codepoint, cp_i.cp_cell_width, cp_i.cluster_cells, cp_i.last);

      if (res_i.valid && res_i.ready) begin
        if (cluster_results_q.size() == 0) begin
          report_mismatch($sformatf("result with class %0d arrived with none pending",
                                    res_i.term_class));
        end else begin
          want = cluster_results_q.pop_front();
          check_field("term_class", 32'(res_i.term_class), 32'(want.term_class));
          check_field("fact_flags", 32'(res_i.fact_flags), 32'(want.fact_flags));
          check_field("cp_total", 32'(res_i.cp_total), 32'(want.cp_total));
          check_field("spacing_total", 32'(res_i.spacing_total), 32'(want.spacing_total));
          check_field("regional_total", 32'(res_i.regional_total),
                      32'(want.regional_total));
          check_field("joiner_total", 32'(res_i.joiner_total), 32'(want.joiner_total));
          check_field("first_cp", 32'(res_i.first_cp), 32'(want.first_cp));
          check_field("keycap_digit", 32'(res_i.keycap_digit), 32'(want.keycap_digit));
          check_field("display_width", 32'(res_i.display_width), 32'(want.display_width));
          if (res_i.term_class < 18) class_seen[res_i.term_class] = 1'b1;
        end
        results_seen++;
      end
      pending_cnt = cluster_results_q.size();
    end
  end

endmodule

### test/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Stimulus for the grapheme cluster classifier. A short directed set covers
// 14 terminal classes and the field extremes, then random clusters follow:
// mostly well-formed emoji, keycap, flag and combining sequences, with noise,
// truncating and saturating clusters, random idling on both sides, a stretch
// without idling and one long receiver hold-off.
// ----------------------------------------------------------------------------
module tb;
  import gcc_pkg::*;

  localparam int CLK_PERIOD   = 10;
  localparam int RANDOM_ITEMS = 1800;
  localparam int HOLD_CYCLES  = 150;
  localparam int DRAIN_CYCLES = 8;
  localparam int CYCLE_LIMIT  = 200000;

  localparam logic [CP_W-1:0] EDGE_CPS [20] = '{
    CP_RI_LO, CP_RI_HI, CP_TAG_LO, CP_TAG_HI, CP_MOD_LO, CP_MOD_HI, CP_EMO_LO,
    CP_EMO_HI, CP_SYM_LO, CP_SYM_HI, CP_PUA_LO, CP_PUA_HI, CP_PUA15_LO,
    CP_PUA15_HI, CP_PUA16_LO, CP_PUA16_HI, CP_DIGIT_LO, CP_DIGIT_HI,
    CP_ASCII_LIM, 21'h10FFFF
  };

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  logic        idle_on;
  logic        hold_req;
  int          hold_cnt;
  int          cycle_cnt;
  int          items_sent;
  int          clusters_sent;
  int          longest;
  int          fail_count;
  int          pending;
  int          results;
  logic [17:0] class_mask;

  logic [CP_W-1:0] cps_q [$];
  logic [CW_W-1:0] cws_q [$];

  gcc_in_if  in_if ();
  gcc_out_if out_if ();

  grapheme_cluster_classifier i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  gcc_cluster_checker i_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cp_i         (in_if),
    .res_i        (out_if),
    .fail_count_o (fail_count),
    .pending_o    (pending),
    .results_o    (results),
    .class_mask_o (class_mask)
  );

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  function automatic logic [CP_W-1:0] pick_cp();
    case ($urandom_range(0, 19))
      0:       return CP_ZWJ;
      1:       return CP_KEYCAP;
      2:       return CP_TEXTVS;
      3:       return CP_EMOJIVS;
      4:       return CP_HEART;
      5:       return CP_W'($urandom_range(CP_RI_LO, CP_RI_HI));
      6:       return CP_W'($urandom_range(CP_TAG_LO, CP_TAG_HI));
      7:       return CP_W'($urandom_range(CP_MOD_LO, CP_MOD_HI));
      8:       return CP_W'($urandom_range(CP_EMO_LO, CP_EMO_HI));
      9:       return CP_W'($urandom_range(CP_SYM_LO, CP_SYM_HI));
      10: begin
        case ($urandom_range(0, 2))
          0:       return CP_W'($urandom_range(CP_PUA_LO, CP_PUA_HI));
          1:       return CP_W'($urandom_range(CP_PUA15_LO, CP_PUA15_HI));
          default: return CP_W'($urandom_range(CP_PUA16_LO, CP_PUA16_HI));
        endcase
      end
      11: begin
        case ($urandom_range(0, 2))
          0:       return CP_HASH;
          1:       return CP_STAR;
          default: return CP_W'($urandom_range(CP_DIGIT_LO, CP_DIGIT_HI));
        endcase
      end
      12:      return CP_W'($urandom_range(0, 16'h7F));
      13:      return EDGE_CPS[$urandom_range(0, 19)] + CP_W'($urandom_range(0, 2)) - 1'b1;
      14:      return CP_W'($urandom_range(21'h110000, 21'h1FFFFF));
      15:      return CP_W'($urandom_range(16'h80, 16'h2FF));
      default: return CP_W'($urandom_range(0, 21'h1FFFFF));
    endcase
  endfunction

  task automatic add_cp(input logic [CP_W-1:0] cp, input logic [CW_W-1:0] cw);
    cps_q.push_back(cp);
    cws_q.push_back(cw);
  endtask

  task automatic send_cp(input logic [CP_W-1:0] cp, input logic [CW_W-1:0] cw,
                         input logic [CELLS_W-1:0] cells, input logic last);
    while (idle_on && $urandom_range(0, 99) < 8) begin
      in_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_if.valid         <= 1'b1;
    in_if.codepoint     <= cp;
    in_if.cp_cell_width <= cw;
    in_if.cluster_cells <= cells;
    in_if.last          <= last;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    items_sent++;
  endtask

  task automatic send_cluster(input logic [CELLS_W-1:0] cells);
    int n;
    n = cps_q.size();
    for (int i = 0; i < n; i++)
      send_cp(cps_q[i], cws_q[i], (i == n - 1) ? cells : CELLS_W'($urandom_range(0, 15)),
              i == n - 1);
    clusters_sent++;
    if (n > longest) longest = n;
    cps_q.delete();
    cws_q.delete();
  endtask

  task automatic build_cluster();
    int kind;
    int n;
    kind = $urandom_range(0, 99);
    if (kind < 12) begin
      // keycap sequence
      case ($urandom_range(0, 2))
        0:       add_cp(CP_HASH, 2'd1);
        1:       add_cp(CP_STAR, 2'd1);
        default: add_cp(CP_W'($urandom_range(CP_DIGIT_LO, CP_DIGIT_HI)), 2'd1);
      endcase
      if ($urandom_range(0, 1)) add_cp(CP_EMOJIVS, 2'd0);
      if ($urandom_range(0, 5) != 0) add_cp(CP_KEYCAP, 2'd0);
    end else if (kind < 24) begin
      // regional indicators, sometimes broken by a stray codepoint
      n = $urandom_range(1, 3);
      repeat (n) add_cp(CP_W'($urandom_range(CP_RI_LO, CP_RI_HI)), 2'd1);
      if ($urandom_range(0, 4) == 0) add_cp(pick_cp(), CW_W'($urandom_range(0, 3)));
    end else if (kind < 32) begin
      // tag sequence flag
      add_cp(21'h1F3F4, 2'd2);
      n = $urandom_range(0, 6);
      repeat (n) add_cp(CP_W'($urandom_range(CP_TAG_LO, CP_TAG_HI)), 2'd0);
      if ($urandom_range(0, 3) != 0) add_cp(CP_TAG_HI, 2'd0);
    end else if (kind < 50) begin
      // zwj sequence
      n = $urandom_range(2, 4);
      for (int i = 0; i < n; i++) begin
        if (i != 0) add_cp(CP_ZWJ, 2'd0);
        if ($urandom_range(0, 4) == 0) add_cp(CP_HEART, CW_W'($urandom_range(1, 2)));
        else add_cp(CP_W'($urandom_range(CP_EMO_LO, CP_EMO_HI)), CW_W'($urandom_range(0, 2)));
        if ($urandom_range(0, 4) == 0) add_cp(CP_EMOJIVS, 2'd0);
        if ($urandom_range(0, 5) == 0) add_cp(CP_W'($urandom_range(CP_MOD_LO, CP_MOD_HI)), 2'd0);
      end
    end else if (kind < 60) begin
      // emoji with modifier or selector
      add_cp(($urandom_range(0, 1)) ? CP_W'($urandom_range(CP_SYM_LO, CP_SYM_HI))
                                    : CP_W'($urandom_range(CP_EMO_LO, CP_EMO_HI)),
             CW_W'($urandom_range(1, 2)));
      case ($urandom_range(0, 2))
        0:       add_cp(CP_W'($urandom_range(CP_MOD_LO, CP_MOD_HI)), 2'd0);
        1:       add_cp(CP_TEXTVS, 2'd0);
        default: add_cp(CP_EMOJIVS, 2'd0);
      endcase
    end else if (kind < 72) begin
      // base with combining marks
      add_cp(CP_W'($urandom_range(16'h41, 16'h2FF)), CW_W'($urandom_range(0, 2)));
      n = $urandom_range(1, 4);
      repeat (n) add_cp(CP_W'($urandom_range(16'h300, 16'h36F)), 2'd0);
    end else if (kind < 85) begin
      add_cp(pick_cp(), CW_W'($urandom_range(0, 3)));
    end else if (kind < 97) begin
      // noise
      n = $urandom_range(1, 6);
      repeat (n) add_cp(pick_cp(), CW_W'($urandom_range(0, 3)));
    end else begin
      // long, often long enough to truncate
      n = $urandom_range(14, 40);
      repeat (n) add_cp(pick_cp(), CW_W'($urandom_range(0, 3)));
    end
  endtask

  // receiver side
  initial begin
    out_if.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        hold_req = 1'b0;
        hold_cnt = 0;
        out_if.ready <= 1'b0;
        while (hold_cnt < HOLD_CYCLES) begin
          @(posedge clk_i);
          hold_cnt++;
        end
      end
      out_if.ready <= !(idle_on && $urandom_range(0, 99) < 8);
    end
  end

  initial begin
    cycle_cnt = 0;
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_cnt++;
    end
    $display("tb failed");
    $finish;
  end

  initial begin
    int   rand_base;
    int   done;
    logic hold_done;
    logic ri_sat_done;
    logic zwj_sat_done;

    in_if.valid         = 1'b0;
    in_if.codepoint     = '0;
    in_if.cp_cell_width = '0;
    in_if.cluster_cells = '0;
    in_if.last          = 1'b0;
    idle_on             = 1'b1;
    hold_req            = 1'b0;
    items_sent          = 0;
    clusters_sent       = 0;
    longest             = 0;
    hold_done           = 1'b0;
    ri_sat_done         = 1'b0;
    zwj_sat_done        = 1'b0;

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed clusters
    add_cp(21'h000000, 2'd0);
    send_cluster(4'd0);
    add_cp(21'h1FFFFF, 2'd3);
    send_cluster(4'd15);
    add_cp(21'h000031, 2'd1); add_cp(CP_EMOJIVS, 2'd0); add_cp(CP_KEYCAP, 2'd0);
    send_cluster(4'd2);
    add_cp(21'h1F1FA, 2'd1); add_cp(21'h1F1F8, 2'd1);
    send_cluster(4'd2);
    add_cp(CP_RI_LO, 2'd1);
    send_cluster(4'd1);
    add_cp(21'h1F3F4, 2'd2); add_cp(21'hE0067, 2'd0); add_cp(CP_TAG_HI, 2'd0);
    send_cluster(4'd2);
    add_cp(21'h1F469, 2'd2); add_cp(CP_ZWJ, 2'd0); add_cp(CP_HEART, 2'd1);
    add_cp(CP_ZWJ, 2'd0); add_cp(21'h1F468, 2'd2);
    send_cluster(4'd2);
    add_cp(21'h1F3F3, 2'd2); add_cp(CP_ZWJ, 2'd0); add_cp(21'h1F308, 2'd2);
    send_cluster(4'd2);
    add_cp(21'h1F44B, 2'd2); add_cp(CP_MOD_HI, 2'd0);
    send_cluster(4'd2);
    add_cp(CP_HEART, 2'd1); add_cp(CP_TEXTVS, 2'd0);
    send_cluster(4'd1);
    add_cp(21'h00263A, 2'd1); add_cp(CP_EMOJIVS, 2'd0);
    send_cluster(4'd2);
    add_cp(CP_PUA_LO, 2'd1);
    send_cluster(4'd1);
    add_cp(21'h0000A9, 2'd1);
    send_cluster(4'd1);
    add_cp(21'h000301, 2'd0);
    send_cluster(4'd0);

    // random clusters
    rand_base = items_sent;
    while (items_sent - rand_base < RANDOM_ITEMS) begin
      done    = items_sent - rand_base;
      idle_on = (done < 700) || (done >= 1100);
      if (done >= 700 && !hold_done) begin
        hold_done = 1'b1;
        hold_req  = 1'b1;
      end
      if (done >= 300 && !ri_sat_done) begin
        ri_sat_done = 1'b1;
        repeat (300) add_cp(CP_W'($urandom_range(CP_RI_LO, CP_RI_HI)),
                            CW_W'($urandom_range(1, 3)));
      end else if (done >= 1300 && !zwj_sat_done) begin
        zwj_sat_done = 1'b1;
        add_cp(21'h1F469, 2'd2);
        repeat (270) add_cp(CP_ZWJ, CW_W'($urandom_range(0, 3)));
      end else begin
        build_cluster();
      end
      send_cluster(($urandom_range(0, 3) == 0) ? CELLS_W'($urandom_range(0, 15))
                                               : CELLS_W'($urandom_range(0, 2)));
    end
    in_if.valid <= 1'b0;

    while (pending != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("sent %0d codepoints in %0d clusters, longest %0d; %0d results checked",
             items_sent, clusters_sent, longest, results);
    $display("%0d of 18 terminal classes seen", $countones(class_mask));
    if (fail_count == 0 && pending == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

endmodule
